>>> src/matrix_3x3_inverse_core_macros.svh
// Assertion macros shared by the 3x3 inverse RTL.
// No dependencies; included by files that carry checks.
`ifndef MATRIX_3X3_INVERSE_CORE_MACROS_SVH
`define MATRIX_3X3_INVERSE_CORE_MACROS_SVH

// same-cycle implication
`define M3INV_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("m3inv: same-cycle check failed");

// next-cycle implication
`define M3INV_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("m3inv: next-cycle check failed");

`endif

>>> src/m3inv_pkg.sv
// Shared widths, types and helpers for the 3x3 inverse pipeline.
// No dependencies.
package m3inv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int EW        = 32;                  // element width
    localparam int NE        = 9;                   // elements per matrix
    localparam int PW        = 2 * EW;              // product width
    localparam int CW        = PW + 1;              // signed cofactor width
    localparam int CMW       = PW;                  // cofactor magnitude width
    localparam int DW        = 98;                  // determinant width
    localparam int TW        = 31;                  // threshold width
    localparam int LIMW      = TW + 2 * FRAC_BITS;  // scaled threshold width
    localparam int QB        = EW + 2;              // quotient bits (one extra for rounding)
    localparam int NW        = CMW + 2 * FRAC_BITS + 1; // doubled, scaled numerator
    localparam int RW0       = NW - QB;             // initial remainder width
    localparam int DIV_LAT   = QB + 2;              // divider latency

    typedef logic [EW-1:0]          elem_t;
    typedef logic [NE-1:0][EW-1:0]  mat_t;
    typedef logic signed [CW-1:0]   cof_t;
    typedef logic [CMW-1:0]         cmag_t;
    typedef logic [DW-1:0]          dmag_t;

    typedef struct packed {
        logic valid;
        logic singular;
        logic dneg;
    } det_info_t;

    function automatic logic signed [PW-1:0] smul(input logic signed [EW-1:0] a,
                                                  input logic signed [EW-1:0] b);
        return a * b;
    endfunction

endpackage

>>> src/m3inv_cofactor.sv
// Stages 1-2: the eighteen element products, then the nine adjugate entries.
// Depends on m3inv_pkg.
module m3inv_cofactor (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  m3inv_pkg::mat_t   in_mat,
    output logic              out_valid,
    output m3inv_pkg::mat_t   out_mat,
    output m3inv_pkg::cof_t   cof [m3inv_pkg::NE]
);

    logic signed [m3inv_pkg::PW-1:0] pa_reg [m3inv_pkg::NE];
    logic signed [m3inv_pkg::PW-1:0] pb_reg [m3inv_pkg::NE];
    logic signed [m3inv_pkg::PW-1:0] pa_next [m3inv_pkg::NE];
    logic signed [m3inv_pkg::PW-1:0] pb_next [m3inv_pkg::NE];
    m3inv_pkg::cof_t                 cof_reg [m3inv_pkg::NE];
    m3inv_pkg::cof_t                 cof_next [m3inv_pkg::NE];
    m3inv_pkg::mat_t                 mat1_reg, mat2_reg;
    logic                            v1_reg, v2_reg, v1_next, v2_next;

    // adj(i,j) is the cofactor of element (j,i)
    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            localparam int R1 = (j + 1) % 3;
            localparam int R2 = (j + 2) % 3;
            localparam int C1 = (i + 1) % 3;
            localparam int C2 = (i + 2) % 3;
            localparam int K  = i * 3 + j;
            always_comb begin
                pa_next[K] = m3inv_pkg::smul(in_mat[R1*3+C1], in_mat[R2*3+C2]);
                pb_next[K] = m3inv_pkg::smul(in_mat[R1*3+C2], in_mat[R2*3+C1]);
                cof_next[K] = m3inv_pkg::CW'(pa_reg[K]) - m3inv_pkg::CW'(pb_reg[K]);
            end
        end
    end

    assign v1_next = in_valid;
    assign v2_next = v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            cof_reg  <= cof_next;
            mat1_reg <= in_mat;
            mat2_reg <= mat1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_mat   = mat2_reg;
    assign cof       = cof_reg;

endmodule

>>> src/m3inv_det.sv
// Stages 3-5: determinant from the first row, magnitudes, singular test.
// Depends on m3inv_pkg.
module m3inv_det (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  m3inv_pkg::mat_t          in_mat,
    input  m3inv_pkg::cof_t          cof [m3inv_pkg::NE],
    input  logic [m3inv_pkg::TW-1:0] thr,
    output m3inv_pkg::det_info_t     info,
    output m3inv_pkg::mat_t          out_mat,
    output m3inv_pkg::dmag_t         dmag,
    output m3inv_pkg::cmag_t         cmag [m3inv_pkg::NE],
    output logic [m3inv_pkg::NE-1:0] cneg
);

    localparam int HW = m3inv_pkg::CW - m3inv_pkg::EW;   // cofactor high part width

    // stage 3: split partial products (cofactor = hi * 2^32 + lo)
    logic signed [m3inv_pkg::EW+HW-1:0] plo_reg [3], plo_next [3];
    logic signed [m3inv_pkg::EW+HW-1:0] phi_reg [3], phi_next [3];
    m3inv_pkg::cof_t                    cof3_reg [m3inv_pkg::NE];
    m3inv_pkg::mat_t                    mat3_reg, mat4_reg, mat5_reg;
    logic                               v3_reg, v4_reg, v5_reg;
    // stage 4
    logic signed [m3inv_pkg::DW-1:0]    det_reg, det_next;
    m3inv_pkg::cmag_t                   cmag4_reg [m3inv_pkg::NE], cmag4_next [m3inv_pkg::NE];
    logic [m3inv_pkg::NE-1:0]           cneg4_reg, cneg4_next;
    // stage 5
    m3inv_pkg::dmag_t                   dmag_reg, dmag_next;
    logic                               dneg_reg, dneg_next, sing_reg, sing_next;
    m3inv_pkg::cmag_t                   cmag5_reg [m3inv_pkg::NE];
    logic [m3inv_pkg::NE-1:0]           cneg5_reg;
    logic [m3inv_pkg::LIMW-1:0]         limit;

    for (genvar k = 0; k < 3; k++) begin : g_pp
        logic signed [m3inv_pkg::EW-1:0] mk;
        logic signed [m3inv_pkg::EW:0]   lo_s;
        logic signed [HW-1:0]            hi_s;
        assign mk   = in_mat[k];
        assign lo_s = {1'b0, cof[3*k][m3inv_pkg::EW-1:0]};
        assign hi_s = cof[3*k][m3inv_pkg::CW-1:m3inv_pkg::EW];
        always_comb begin
            plo_next[k] = (m3inv_pkg::EW+HW)'(mk) * (m3inv_pkg::EW+HW)'(lo_s);
            phi_next[k] = (m3inv_pkg::EW+HW)'(mk) * (m3inv_pkg::EW+HW)'(hi_s);
        end
    end

    always_comb begin
        det_next = '0;
        for (int k = 0; k < 3; k++) begin
            det_next = det_next + (m3inv_pkg::DW'(phi_reg[k]) <<< m3inv_pkg::EW)
                                + m3inv_pkg::DW'(plo_reg[k]);
        end
        for (int k = 0; k < m3inv_pkg::NE; k++) begin
            cneg4_next[k] = cof3_reg[k][m3inv_pkg::CW-1];
            cmag4_next[k] = cneg4_next[k] ? m3inv_pkg::CMW'(-cof3_reg[k])
                                          : m3inv_pkg::CMW'(cof3_reg[k]);
        end
        dneg_next = det_reg[m3inv_pkg::DW-1];
        dmag_next = dneg_next ? m3inv_pkg::dmag_t'(-det_reg) : m3inv_pkg::dmag_t'(det_reg);
        limit     = m3inv_pkg::LIMW'(thr) << (2 * m3inv_pkg::FRAC_BITS);
        sing_next = (dmag_next == '0) || (dmag_next < m3inv_pkg::DW'(limit));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            cof3_reg  <= cof;
            mat3_reg  <= in_mat;
            det_reg   <= det_next;
            cmag4_reg <= cmag4_next;
            cneg4_reg <= cneg4_next;
            mat4_reg  <= mat3_reg;
            dmag_reg  <= dmag_next;
            dneg_reg  <= dneg_next;
            sing_reg  <= sing_next;
            cmag5_reg <= cmag4_reg;
            cneg5_reg <= cneg4_reg;
            mat5_reg  <= mat4_reg;
        end
    end

    assign info.valid    = v5_reg;
    assign info.singular = sing_reg;
    assign info.dneg     = dneg_reg;
    assign out_mat       = mat5_reg;
    assign dmag          = dmag_reg;
    assign cmag          = cmag5_reg;
    assign cneg          = cneg5_reg;

endmodule

>>> src/m3inv_divider.sv
// Pipelined restoring divider for one element: one quotient bit per stage,
// then round half away from zero, sign and clamp. Depends on m3inv_pkg.
module m3inv_divider (
    input  logic              aclk,
    input  logic              en,
    input  m3inv_pkg::cmag_t  cmag,
    input  logic              neg,
    input  m3inv_pkg::dmag_t  dmag,
    output m3inv_pkg::elem_t  res,
    output logic              sat
);

    localparam int QB = m3inv_pkg::QB;
    localparam int DW = m3inv_pkg::DW;

    m3inv_pkg::dmag_t rem_reg  [QB+1];
    m3inv_pkg::dmag_t dv_reg   [QB+1];
    logic [QB-1:0]    low_reg  [QB+1];
    logic [QB-1:0]    q_reg    [QB+1];
    logic             neg_reg  [QB+1];
    logic             ovf_reg  [QB+1];
    m3inv_pkg::elem_t res_reg, res_next;
    logic             sat_reg, sat_next;

    logic [m3inv_pkg::NW-1:0]  twon;
    logic [m3inv_pkg::RW0-1:0] r0;
    logic [QB:0]               qr;

    // numerator doubled so the extra quotient bit drives rounding
    assign twon = {cmag, (2 * m3inv_pkg::FRAC_BITS + 1)'(0)};
    assign r0   = twon[m3inv_pkg::NW-1:QB];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= DW'(r0);
            dv_reg[0]  <= dmag;
            low_reg[0] <= twon[QB-1:0];
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            ovf_reg[0] <= (DW'(r0) >= dmag);
        end
    end

    for (genvar s = 1; s <= QB; s++) begin : g_stage
        logic [DW:0] t;
        logic        ge;
        assign t  = {rem_reg[s-1], low_reg[s-1][QB-1]};
        assign ge = (t >= {1'b0, dv_reg[s-1]});
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= ge ? DW'(t - {1'b0, dv_reg[s-1]}) : DW'(t);
                dv_reg[s]  <= dv_reg[s-1];
                low_reg[s] <= low_reg[s-1] << 1;
                q_reg[s]   <= {q_reg[s-1][QB-2:0], ge};
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end
    end

    localparam logic [QB:0] POS_MAX = (QB+1)'({1'b0, {(m3inv_pkg::EW-1){1'b1}}});
    localparam logic [QB:0] NEG_MAX = (QB+1)'({1'b1, {(m3inv_pkg::EW-1){1'b0}}});

    always_comb begin
        qr = ({1'b0, q_reg[QB]} + (QB+1)'(1)) >> 1;
        if (ovf_reg[QB] || (neg_reg[QB] ? (qr > NEG_MAX) : (qr > POS_MAX))) begin
            sat_next = 1'b1;
            res_next = neg_reg[QB] ? m3inv_pkg::elem_t'(NEG_MAX) : m3inv_pkg::elem_t'(POS_MAX);
        end else begin
            sat_next = 1'b0;
            res_next = neg_reg[QB] ? m3inv_pkg::elem_t'(-qr) : m3inv_pkg::elem_t'(qr);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

>>> src/matrix_3x3_inverse_core.sv
// Pipeline from input accept to result: 2 product/cofactor, 3 determinant and 36 divider
// stages, with a 34-bit quotient one bit per stage, output register included.
// Throughput: one matrix per cycle; a stall at the output freezes the whole pipeline.
// Reset (aresetn low, synchronous) empties the pipeline and sets the singular threshold to 1.
`include "matrix_3x3_inverse_core_macros.svh"
module matrix_3x3_inverse_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,   // m00,m01,m02,m10,m11,m12,m20,m21,m22 (32b each, lsb first)
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [287:0] m_tdata,   // r00,r01,r02,r10,r11,r12,r20,r21,r22 (32b each, lsb first)
    output logic [1:0]   m_tuser,   // singular, saturated
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [30:0]  cfg_data
);

    localparam int LAT = m3inv_pkg::DIV_LAT;

    logic                          en;
    logic [m3inv_pkg::TW-1:0]      thr_reg, thr_next;
    m3inv_pkg::mat_t               in_mat, cof_mat, det_mat;
    logic                          cof_valid;
    m3inv_pkg::cof_t               cof [m3inv_pkg::NE];
    m3inv_pkg::det_info_t          dinfo;
    m3inv_pkg::dmag_t              dmag;
    m3inv_pkg::cmag_t              cmag [m3inv_pkg::NE];
    logic [m3inv_pkg::NE-1:0]      cneg;
    m3inv_pkg::elem_t              res [m3inv_pkg::NE];
    logic [m3inv_pkg::NE-1:0]      sat;
    logic [LAT-1:0]                v_pipe_reg, sing_pipe_reg;
    m3inv_pkg::mat_t               mat_pipe_reg [LAT];

    assign en        = m_tready || !m_tvalid;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign in_mat    = m3inv_pkg::mat_t'(s_tdata);
    assign thr_next  = cfg_valid ? cfg_data : thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= m3inv_pkg::TW'(1);
        end else begin
            thr_reg <= thr_next;
        end
    end

    m3inv_cofactor u_cof (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_mat    (in_mat),
        .out_valid (cof_valid),
        .out_mat   (cof_mat),
        .cof       (cof)
    );

    m3inv_det u_det (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (cof_valid),
        .in_mat   (cof_mat),
        .cof      (cof),
        .thr      (thr_reg),
        .info     (dinfo),
        .out_mat  (det_mat),
        .dmag     (dmag),
        .cmag     (cmag),
        .cneg     (cneg)
    );

    for (genvar k = 0; k < m3inv_pkg::NE; k++) begin : g_div
        m3inv_divider u_div (
            .aclk (aclk),
            .en   (en),
            .cmag (cmag[k]),
            .neg  (cneg[k] ^ dinfo.dneg),
            .dmag (dmag),
            .res  (res[k]),
            .sat  (sat[k])
        );
        assign m_tdata[k*m3inv_pkg::EW +: m3inv_pkg::EW] =
            sing_pipe_reg[LAT-1] ? mat_pipe_reg[LAT-1][k] : res[k];
    end

    // side pipeline matching the divider latency
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_pipe_reg <= '0;
        end else if (en) begin
            v_pipe_reg <= {v_pipe_reg[LAT-2:0], dinfo.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sing_pipe_reg   <= {sing_pipe_reg[LAT-2:0], dinfo.singular};
            mat_pipe_reg[0] <= det_mat;
            for (int s = 1; s < LAT; s++) begin
                mat_pipe_reg[s] <= mat_pipe_reg[s-1];
            end
        end
    end

    assign m_tvalid   = v_pipe_reg[LAT-1];
    assign m_tuser[0] = sing_pipe_reg[LAT-1];
    assign m_tuser[1] = !sing_pipe_reg[LAT-1] && (|sat);

    `M3INV_ASSERT_IMP(a_sing_no_sat, aclk, aresetn, m_tvalid && m_tuser[0], !m_tuser[1])
    `M3INV_ASSERT_NXT(a_freeze_on_stall, aclk, aresetn, !en, $stable(v_pipe_reg))
    `M3INV_ASSERT_IMP(a_no_take_when_blocked, aclk, aresetn, m_tvalid && !m_tready, !s_tready)

endmodule

>>> tb/matrix_3x3_inverse_core_tb.sv
// Self-checking bench for matrix_3x3_inverse_core: directed and random 3x3 Q16.16
// matrices, an adjugate-inverse predictor and field-by-field result checks.
// Depends on m3inv_pkg and the core RTL.
module matrix_3x3_inverse_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] ONE_Q   = 32'h0001_0000;
    localparam logic [31:0] EL_MIN  = 32'h8000_0000;
    localparam logic [31:0] EL_MAX  = 32'h7fff_ffff;
    localparam int          T_LIMIT = 600000;

    typedef struct {
        m3inv_pkg::mat_t r;
        logic singular;
        logic saturated;
    } inv_res_t;

    typedef struct {
        m3inv_pkg::mat_t a;
        bit       typed;  // expected result written into the row
        inv_res_t res;
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;     // m00..m22, 32b each, lsb first
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [287:0] m_tdata;          // r00..r22, 32b each, lsb first
    logic [1:0]   m_tuser;          // singular, saturated
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [30:0]  cfg_data = '0;

    inv_res_t    inverse_q[$];
    stim_row_t   pending_rows[$];
    logic [30:0] thr_model = 31'd1;
    int          fails = 0;
    int          cycles = 0;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;

    matrix_3x3_inverse_core dut (.*);

    always #5 aclk = ~aclk;

    function automatic inv_res_t invert_q16(m3inv_pkg::mat_t a, logic [30:0] thr);
        logic signed [127:0] m [3][3];
        logic signed [127:0] cof [3][3];
        logic signed [127:0] det, c;
        logic [127:0] dmag, lim, num, q, rem;
        logic dneg, neg;
        inv_res_t o;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = {{96{a[i*3+j][31]}}, a[i*3+j]};
        // cof[i][j] is the cofactor of element (j, i)
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                cof[i][j] = m[(j+1)%3][(i+1)%3] * m[(j+2)%3][(i+2)%3]
                          - m[(j+1)%3][(i+2)%3] * m[(j+2)%3][(i+1)%3];
        det  = cof[0][0] * m[0][0] + cof[1][0] * m[0][1] + cof[2][0] * m[0][2];
        dneg = det[127];
        dmag = dneg ? -det : det;
        lim  = {97'b0, thr} << (2 * m3inv_pkg::FRAC_BITS);
        o.saturated = 1'b0;
        if (dmag == 0 || dmag < lim) begin
            o.r = a;
            o.singular = 1'b1;
            return o;
        end
        o.singular = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                c   = cof[i][j];
                neg = c[127] != dneg;
                num = (c[127] ? -c : c) << (2 * m3inv_pkg::FRAC_BITS);
                q   = num / dmag;
                rem = num % dmag;
                if ((rem << 1) >= dmag) q = q + 1;
                if (q[127:32] != 0) begin
                    o.saturated = 1'b1;
                    o.r[i*3+j] = neg ? EL_MIN : EL_MAX;
                end else if (neg) begin
                    if (q[31:0] > 32'h8000_0000) begin
                        o.saturated = 1'b1;
                        o.r[i*3+j] = EL_MIN;
                    end else begin
                        o.r[i*3+j] = -q[31:0];
                    end
                end else if (q[31:0] > EL_MAX) begin
                    o.saturated = 1'b1;
                    o.r[i*3+j] = EL_MAX;
                end else begin
                    o.r[i*3+j] = q[31:0];
                end
            end
        end
        return o;
    endfunction

    function automatic m3inv_pkg::mat_t diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        m3inv_pkg::mat_t x = '0;
        x[0] = a;
        x[4] = b;
        x[8] = c;
        return x;
    endfunction

    function automatic logic [31:0] small_el(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic m3inv_pkg::mat_t rand_mat();
        m3inv_pkg::mat_t x;
        logic [31:0] picks [6] = '{EL_MIN, EL_MAX, 32'h0, 32'h1, 32'hffff_ffff, ONE_Q};
        int kind = $urandom_range(0, 9);
        int span = 1 << $urandom_range(8, 20);
        for (int k = 0; k < 9; k++) begin
            case (kind)
                0:       x[k] = $urandom;
                1:       x[k] = picks[$urandom_range(0, 5)];
                default: x[k] = small_el(span);
            endcase
        end
        case (kind)
            2: for (int k = 0; k < 3; k++) x[6+k] = x[k];              // repeated row
            3: for (int k = 0; k < 3; k++) x[k*3+2] = x[k*3] + x[k*3+1]; // dependent column
            4, 5: for (int k = 0; k < 3; k++) x[k*4] = x[k*4] + 4 * span; // well conditioned
            default: ;
        endcase
        return x;
    endfunction

    // monitor: predictions on input accept, checks on result accept
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) thr_model <= cfg_data;
            if (s_tvalid && s_tready) begin
                stim_row_t row;
                row = pending_rows.pop_front();
                inverse_q.push_back(row.typed ? row.res : invert_q16(s_tdata, thr_model));
            end
            if (m_tvalid && m_tready) begin
                inv_res_t e;
                m3inv_pkg::mat_t got;
                if (inverse_q.size() == 0) begin
                    $error("result with no expectation waiting");
                    fails++;
                end else begin
                    e = inverse_q.pop_front();
                    got = m_tdata;
                    for (int k = 0; k < 9; k++)
                        if (got[k] !== e.r[k]) begin
                            $error("r%0d%0d: expected %h, got %h", k / 3, k % 3, e.r[k], got[k]);
                            fails++;
                        end
                    if (m_tuser[0] !== e.singular) begin
                        $error("singular: expected %b, got %b", e.singular, m_tuser[0]);
                        fails++;
                    end
                    if (m_tuser[1] !== e.saturated) begin
                        $error("saturated: expected %b, got %b", e.saturated, m_tuser[1]);
                        fails++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > T_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 19);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                n = $urandom_range(1, 30);
                m_tready <= 1'b1;
                repeat (n) @(posedge aclk);
            end
        end
    end

    task automatic send_item(stim_row_t row);
        pending_rows.push_back(row);
        s_tvalid <= 1'b1;
        s_tdata  <= row.a;
        do @(posedge aclk); while (!s_tready);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (inverse_q.size() != 0 || pending_rows.size() != 0) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [30:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_phase(int n);
        stim_row_t row;
        row.typed = 1'b0;
        row.res = '{default: '0};
        repeat (n) begin
            row.a = rand_mat();
            send_item(row);
        end
    endtask

    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        m3inv_pkg::mat_t x;

        // typed rows: identity, zero, uniform scalings, all-extreme echo
        row.typed = 1'b1;
        row.a = diag(ONE_Q, ONE_Q, ONE_Q);
        row.res = '{row.a, 1'b0, 1'b0};
        rows.push_back(row);
        row.a = '0;
        row.res = '{row.a, 1'b1, 1'b0};
        rows.push_back(row);
        row.a = diag(32'h2_0000, 32'h2_0000, 32'h2_0000);
        row.res = '{diag(32'h8000, 32'h8000, 32'h8000), 1'b0, 1'b0};
        rows.push_back(row);
        row.a = diag(32'h8000, 32'h8000, 32'h8000);
        row.res = '{diag(32'h2_0000, 32'h2_0000, 32'h2_0000), 1'b0, 1'b0};
        rows.push_back(row);
        row.a = diag(-ONE_Q, -ONE_Q, -ONE_Q);
        row.res = '{row.a, 1'b0, 1'b0};
        rows.push_back(row);
        row.a = {9{EL_MIN}};
        row.res = '{row.a, 1'b1, 1'b0};
        rows.push_back(row);
        row.a = {9{EL_MAX}};
        row.res = '{row.a, 1'b1, 1'b0};
        rows.push_back(row);

        // predicted rows
        row.typed = 1'b0;
        row.res = '{default: '0};
        foreach (x[k]) x[k] = '0;
        row.a = diag(32'h3_0000, 32'h3_0000, 32'h3_0000);           rows.push_back(row);
        row.a = diag(32'h1, 32'h1, 32'h1);                           rows.push_back(row);
        row.a = diag(32'h800, 32'h800, 32'h800);                     rows.push_back(row);
        row.a = diag(32'h4000_0000, 32'h4000_0000, 32'h1);           rows.push_back(row);
        row.a = diag(32'h4000_0000, 32'hc000_0000, 32'h1);           rows.push_back(row);
        row.a = diag(EL_MAX, EL_MAX, EL_MAX);                        rows.push_back(row);
        row.a = diag(EL_MIN, EL_MIN, EL_MIN);                        rows.push_back(row);
        row.a = diag(EL_MIN, EL_MAX, 32'h1);                         rows.push_back(row);
        row.a = diag(32'h1_8000, 32'hfffe_8000, 32'h5_0000);         rows.push_back(row);
        row.a = {EL_MAX, EL_MIN, 32'h0, 32'h1, EL_MAX, EL_MIN, EL_MIN, 32'h0, EL_MAX};
        rows.push_back(row);
        row.a = {32'h2_0000, 32'h1_0000, 32'h0, 32'h1_0000, 32'h3_0000,
                 32'h1_0000, 32'h0, 32'h1_0000, 32'h4_0000};
        rows.push_back(row);
        row.a = {32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h1_0000, 32'h2_0000,
                 32'h3_0000, 32'h5_0000, 32'h7_0000, 32'h1_0000};
        rows.push_back(row);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset threshold of one
        foreach (rows[i]) send_item(rows[i]);
        random_phase(60);
        drain();

        write_threshold(31'd0);
        random_phase(200);
        drain();

        write_threshold(31'h7fff_ffff);
        random_phase(80);
        drain();

        // back pressure: receiver holds off while the sender keeps offering
        write_threshold(31'd1);
        hold_req = 1'b1;
        random_phase(200);
        drain();

        repeat (4) begin
            write_threshold(31'($urandom_range(0, 3) == 0 ? $urandom
                                                          : $urandom_range(0, 1 << 12)));
            random_phase(100);
            drain();
        end

        write_threshold(31'd1);
        no_idle = 1'b1;
        random_phase(100);
        drain();

        repeat (60) @(posedge aclk);
        if (fails == 0 && inverse_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
